// ===== hdl/thermal_throttle_manager_macros.svh =====
// ----------------------------------------------------------------------------
// Thermal throttle manager assertion macros
// Shared concurrent assertion helpers, clocked on the rising edge and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef THERMAL_THROTTLE_MANAGER_MACROS_SVH
`define THERMAL_THROTTLE_MANAGER_MACROS_SVH

// Condition must hold at every edge outside reset.
`define TTM_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define TTM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/ttm_pkg.sv =====
// ----------------------------------------------------------------------------
// Thermal throttle manager package
// Command codes, register indexes and fixed operating-point constants.
// ----------------------------------------------------------------------------
package ttm_pkg;

   // Field widths
   localparam int FUNC_W   = 3;
   localparam int SLOTS_W  = 8;
   localparam int TEMP_W   = 17;
   localparam int HYST_W   = 15;
   localparam int FREQ_W   = 22;
   localparam int TDP_W    = 16;
   localparam int TICK_W   = 64;
   localparam int TLOW_W   = 32;
   localparam int CNT_O_W  = 5;
   localparam int POS_O_W  = 4;
   localparam int PER_W    = 15;
   localparam int CSR_IDX_W = 2;
   localparam int RSP_DATA_W = 120;

   typedef logic [FUNC_W-1:0]    func_type;
   typedef logic [TEMP_W-1:0]    temp_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   // Command codes
   localparam func_type FUNC_STATUS    = 3'd0;
   localparam func_type FUNC_FORCE_ON  = 3'd1;
   localparam func_type FUNC_FORCE_OFF = 3'd2;
   localparam func_type FUNC_HISTORY   = 3'd3;
   localparam func_type FUNC_CLEAR     = 3'd4;
   localparam func_type FUNC_TICK      = 3'd5;

   // Register indexes
   localparam csr_idx_type REG_THRESHOLD  = 2'd0;
   localparam csr_idx_type REG_HYSTERESIS = 2'd1;

   // Temperatures in millidegrees
   localparam temp_type T_MIN        = 17'd25000;
   localparam temp_type T_MAX        = 17'd95000;
   localparam temp_type T_INIT       = 17'd45000;
   localparam temp_type THRESH_RESET = 17'd80000;
   localparam logic [HYST_W-1:0] HYST_RESET = 15'd5000;
   localparam logic [10:0] HEAT_PER_SLOT = 11'd1500;
   localparam logic [10:0] COOL_PER_TICK = 11'd2000;

   // Operating points
   localparam logic [FREQ_W-1:0] F_NOM = 22'd2800000;
   localparam logic [FREQ_W-1:0] F_LOW = 22'd1400000;
   localparam logic [TDP_W-1:0]  P_NOM = 16'd60000;
   localparam logic [TDP_W-1:0]  P_LOW = 16'd30000;
   localparam logic [PER_W-1:0]  PER_SLOW = 15'd20000;
   localparam logic [PER_W-1:0]  PER_FAST = 15'd10000;
   localparam logic [PER_W-1:0]  PER_NONE = 15'd0;

endpackage

// ===== hdl/thermal_throttle_manager.sv =====
// ----------------------------------------------------------------------------
// Thermal throttle manager
// Simulated die temperature with hysteretic throttling and a history ring.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one command per request; req_tuser holds the command code,
//   req_tdata the active slot count used by a tick.
//   rsp_ channel: exactly one result per request, showing the operating point,
//   temperature, tick count, history ring position and any GPU period request.
//   csr_ channel: register writes (index 0 threshold, 1 hysteresis), always
//   ready; a threshold outside 25000..95000 is dropped.
// Latency and throughput:
//   A request accepted at one edge shows its result on rsp_ from the next
//   cycle. One request per cycle is sustained while rsp_tready is high; the
//   clamped sum and compare feeding the result register is combinational.
// Reset:
//   Synchronous reset restores temperature 45000, flag clear, tick count and
//   ring head zero, and the register reset values. No result is pending.
// Stall:
//   While rsp_tvalid is high and rsp_tready is low the result holds and
//   req_tready drops; a taken result frees the slot in the same cycle.
// ----------------------------------------------------------------------------
`include "thermal_throttle_manager_macros.svh"

module thermal_throttle_manager #(
   parameter int HIST_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // [7:0] slot_count
   input  logic [ttm_pkg::FUNC_W-1:0]          req_tuser,  // [2:0] func
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [16:0] temp_mc, [38:17] core_freq, [39] throttled, [55:40] tdp_mw,
   // [87:56] tick_low, [92:88] hist_count, [96:93] hist_pos,
   // [97] sample_written, [112:98] period_request_us, [119:113] zero
   output logic [ttm_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ttm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ttm_pkg::TEMP_W-1:0]          csr_wdata
);
   import ttm_pkg::*;

   localparam int HEAD_W = $clog2(HIST_DEPTH);
   localparam int CNT_W  = $clog2(HIST_DEPTH + 1);
   localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(HIST_DEPTH - 1);
   localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(HIST_DEPTH);

   // Registers
   temp_type              thresh_ff;
   logic [HYST_W-1:0]     hyst_ff;
   temp_type              temp_ff,  temp_in;
   logic                  flag_ff,  flag_in;
   logic [TICK_W-1:0]     tick_ff,  tick_in;
   logic [HEAD_W-1:0]     head_ff,  head_in;
   logic [CNT_W-1:0]      cnt_ff,   cnt_in;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Per-request working values
   func_type              func;
   logic [19:0]           heat_sum;
   temp_type              temp_clamped;
   logic signed [18:0]    release_lvl;
   logic [PER_W-1:0]      period;
   logic                  written;
   logic [HEAD_W-1:0]     pos;
   logic [HEAD_W+POS_O_W-1:0] pos_ext;
   logic [CNT_W+CNT_O_W-1:0]  cnt_ext;
   logic                  req_fire;

   assign func      = req_tuser;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire  = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   // Tick temperature: heat by slots, fixed cooling, clamp to the die range
   always_comb begin
      heat_sum = 20'(temp_ff) + 20'(req_tdata) * 20'(HEAT_PER_SLOT) - 20'(COOL_PER_TICK);
      if (heat_sum < 20'(T_MIN)) begin
         temp_clamped = T_MIN;
      end else if (heat_sum > 20'(T_MAX)) begin
         temp_clamped = T_MAX;
      end else begin
         temp_clamped = heat_sum[TEMP_W-1:0];
      end
      release_lvl = $signed({2'b00, thresh_ff}) - $signed({4'b0000, hyst_ff});
   end

   // Command decode and next state
   always_comb begin
      temp_in = temp_ff;
      flag_in = flag_ff;
      tick_in = tick_ff;
      head_in = head_ff;
      cnt_in  = cnt_ff;
      period  = PER_NONE;
      written = 1'b0;
      pos     = head_ff;
      unique case (func)
         FUNC_FORCE_ON: begin
            if (!flag_ff) begin
               flag_in = 1'b1;
               period  = PER_SLOW;
            end
         end
         FUNC_FORCE_OFF: begin
            if (flag_ff) begin
               flag_in = 1'b0;
               period  = PER_FAST;
            end
         end
         FUNC_CLEAR: begin
            temp_in = T_INIT;
            flag_in = 1'b0;
            tick_in = '0;
            head_in = '0;
            cnt_in  = '0;
            pos     = '0;
         end
         FUNC_TICK: begin
            temp_in = temp_clamped;
            tick_in = tick_ff + 64'd1;
            written = 1'b1;
            head_in = (head_ff == HEAD_LAST) ? '0 : head_ff + HEAD_W'(1);
            cnt_in  = (cnt_ff == CNT_FULL) ? cnt_ff : cnt_ff + CNT_W'(1);
            if (!flag_ff && (temp_clamped > thresh_ff)) begin
               flag_in = 1'b1;
               period  = PER_SLOW;
            end else if (flag_ff && ($signed({2'b00, temp_clamped}) < release_lvl)) begin
               flag_in = 1'b0;
               period  = PER_FAST;
            end
         end
         default: begin
            // status, history and unused codes change nothing
         end
      endcase
   end

   // Result packing, first field in the lowest bits
   assign pos_ext = {{POS_O_W{1'b0}}, pos};
   assign cnt_ext = {{CNT_O_W{1'b0}}, cnt_in};
   assign rsp_data_in = {
      7'd0,
      period,
      written,
      pos_ext[POS_O_W-1:0],
      cnt_ext[CNT_O_W-1:0],
      tick_in[TLOW_W-1:0],
      (flag_in ? P_LOW : P_NOM),
      flag_in,
      (flag_in ? F_LOW : F_NOM),
      temp_in
   };

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
         hyst_ff   <= HYST_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_THRESHOLD: begin
               if ((csr_wdata >= T_MIN) && (csr_wdata <= T_MAX)) begin
                  thresh_ff <= csr_wdata;
               end
            end
            REG_HYSTERESIS: hyst_ff <= csr_wdata[HYST_W-1:0];
            default: ;
         endcase
      end
   end

   // Thermal state
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff <= T_INIT;
         flag_ff <= 1'b0;
         tick_ff <= '0;
         head_ff <= '0;
         cnt_ff  <= '0;
      end else if (req_fire) begin
         temp_ff <= temp_in;
         flag_ff <= flag_in;
         tick_ff <= tick_in;
         head_ff <= head_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Assertions
   `TTM_ASSERT_NEXT(a_tick_writes_sample, clock, reset,
      req_fire && (func == FUNC_TICK), rsp_valid_ff && rsp_data_ff[97],
      "tick did not report a history sample")
   `TTM_ASSERT_ALWAYS(a_head_in_ring, clock, reset, head_ff <= HEAD_LAST,
      "ring head outside the history ring")
   `TTM_ASSERT_ALWAYS(a_count_bounded, clock, reset, cnt_ff <= CNT_FULL,
      "history count above depth")
   `TTM_ASSERT_ALWAYS(a_temp_in_range, clock, reset,
      (temp_ff >= T_MIN) && (temp_ff <= T_MAX), "die temperature outside clamp range")

endmodule
